// ===== rtl/kbps_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed byte-pair substitution package
// Shared command codes, mode codes, register indexes, reset values and the
// control bundle that the run sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package kbps_pkg;

  localparam int BLOCK_BYTES_DEF = 256;
  localparam int NUM_TABLES_DEF  = 4;
  localparam int PAIR_SLOTS      = 65536;
  localparam int STEP_W          = 9;

  localparam logic [2:0] CMD_WR_PAIR  = 3'd0;
  localparam logic [2:0] CMD_WR_BYTE  = 3'd1;
  localparam logic [2:0] CMD_WR_KEY   = 3'd2;
  localparam logic [2:0] CMD_WR_BLOCK = 3'd3;
  localparam logic [2:0] CMD_RUN      = 3'd4;
  localparam logic [2:0] CMD_RD_BLOCK = 3'd5;

  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_SPACING    = 2'd1;
  localparam logic [1:0] REG_PAIR_COUNT = 2'd2;

  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_ADJ   = 2'd1,
    MODE_WRAP  = 2'd2,
    MODE_KEYED = 2'd3
  } mode_t;

  localparam mode_t      MODE_RESET       = MODE_ADJ;
  localparam logic [2:0] SPACING_RESET    = 3'd0;
  localparam logic [7:0] PAIR_COUNT_RESET = 8'd128;

  typedef struct packed {
    logic busy;
    logic rd;
    logic lk;
    logic wa;
    logic wb;
    logic fin;
  } run_ctl_t;

endpackage

// ===== rtl/kbps_run_ctl.sv =====
// ----------------------------------------------------------------------------
// Run sequencer
// Walks the block one pair (or one byte in byte map mode) at a time:
// read the block bytes and key, look up the table, write the bytes back.
// ----------------------------------------------------------------------------
module kbps_run_ctl import kbps_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  localparam int AW   = $clog2(BLOCK_BYTES),
  localparam int HALF = BLOCK_BYTES / 2,
  localparam int KAW  = (HALF > 1) ? $clog2(HALF) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             hold,
  input  mode_t            mode,
  input  logic [2:0]       spacing,
  input  logic [7:0]       pair_count,
  output run_ctl_t         ctl,
  output logic [AW-1:0]    addr_a,
  output logic [AW-1:0]    addr_b,
  output logic [KAW-1:0]   key_addr
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WAIT = 6'b000010,
    S_RD   = 6'b000100,
    S_LK   = 6'b001000,
    S_WA   = 6'b010000,
    S_WB   = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] steps;
  logic [STEP_W-1:0] steps_next;
  logic [7:0]        pairs;
  logic              last;
  logic [9:0]        t10;
  logic [9:0]        a_full;
  logic [9:0]        b_full;

  always_comb begin
    pairs = (32'(pair_count) > HALF) ? 8'(HALF) : pair_count;
    case (mode)
      MODE_BYTE:  steps_next = {pairs, 1'b0};
      MODE_KEYED: steps_next = STEP_W'((pairs >> spacing) << spacing);
      default:    steps_next = STEP_W'(pairs);
    endcase
  end

  assign last = (step == steps - 1'b1);
  assign t10  = 10'(step);

  always_comb begin
    case (mode)
      MODE_BYTE: begin
        a_full = t10;
        b_full = t10;
      end
      MODE_ADJ: begin
        a_full = t10 << 1;
        b_full = (t10 << 1) + 10'd1;
      end
      MODE_WRAP: begin
        a_full = (t10 << 1) + 10'd1;
        b_full = last ? 10'd0 : (t10 << 1) + 10'd2;
      end
      default: begin
        a_full = t10 + ((t10 >> spacing) << spacing);
        b_full = a_full + (10'd1 << spacing);
      end
    endcase
  end

  assign addr_a   = AW'(a_full);
  assign addr_b   = AW'(b_full);
  assign key_addr = KAW'(step);

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.busy   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_WAIT;
      end
      S_WAIT: begin
        if (!hold) begin
          if (steps_next == '0) begin
            ctl.fin    = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        ctl.rd     = 1'b1;
        state_next = S_LK;
      end
      S_LK: begin
        ctl.lk     = 1'b1;
        state_next = S_WA;
      end
      S_WA: begin
        ctl.wa = 1'b1;
        if (mode != MODE_BYTE) begin
          state_next = S_WB;
        end else if (last) begin
          ctl.fin    = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_RD;
        end
      end
      S_WB: begin
        ctl.wb = 1'b1;
        if (last) begin
          ctl.fin    = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      steps <= '0;
    end else begin
      state <= state_next;
      if (state == S_WAIT) begin
        step  <= '0;
        steps <= steps_next;
      end else if (state_next == S_RD) begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/keyed_byte_pair_substitution_unit.sv =====
// ----------------------------------------------------------------------------
// Keyed byte-pair substitution unit
// Holds pair tables, a byte table, key entries and a byte block in memories
// and substitutes the block in place on a run command.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the input channel (in_valid, in_stall) and each one gives
// exactly one result beat on the output channel (out_valid, out_stall).
// Load and read items take one memory access each; their result passes the
// pending stage and then the output register, and a new item can be taken
// every cycle while the output is drained.
// A run item holds in_stall high while the sequencer walks the block. Each
// pair goes through block and key read, table lookup and two write-backs,
// and each byte in byte map mode through read, lookup and one write-back;
// pairs need two write-backs since the block memory has one write port.
// When the receiver stalls, one result waits in the output register and one
// more in the stage before it; after that in_stall rises.
// Reset clears the handshake state and the configuration registers; the
// memories are not cleared and hold no defined value until written.
// Configuration writes are always taken; users must keep them to idle periods.
// ----------------------------------------------------------------------------
module keyed_byte_pair_substitution_unit import kbps_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int NUM_TABLES  = NUM_TABLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [1:0]  table_sel,
  input  logic [15:0] index,
  input  logic [15:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        run_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW     = $clog2(BLOCK_BYTES);
  localparam int HALF   = BLOCK_BYTES / 2;
  localparam int KAW    = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int TW     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int PDEPTH = NUM_TABLES * PAIR_SLOTS;
  localparam int PAW    = $clog2(PDEPTH);

  mode_t       mode;
  logic [2:0]  spacing;
  logic [7:0]  pair_count;

  logic [15:0] pair_mem  [PDEPTH];
  logic [7:0]  byte_mem  [256];
  logic [1:0]  key_mem   [HALF];
  logic [7:0]  block_mem [BLOCK_BYTES];

  logic [15:0] pair_q;
  logic [7:0]  byte_q;
  logic [1:0]  key_q;
  logic [7:0]  blk_a_q;
  logic [7:0]  blk_b_q;

  run_ctl_t      ctl;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [KAW-1:0] key_addr;

  logic           acc;
  logic           blk_idx_ok;
  logic           blk_wr;
  logic [AW-1:0]  blk_wr_addr;
  logic [7:0]     blk_wr_data;
  logic           blk_rd;
  logic [AW-1:0]  blk_rd_addr;
  logic [1:0]     key_m;
  logic [TW-1:0]  tbl;

  logic pend_valid;
  logic pend_rd;
  logic pend_done;
  logic pend_move;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_RESET;
      spacing    <= SPACING_RESET;
      pair_count <= PAIR_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:       mode       <= mode_t'(cfg_data[1:0]);
        REG_SPACING:    spacing    <= cfg_data[2:0];
        REG_PAIR_COUNT: pair_count <= cfg_data;
        default: ;
      endcase
    end
  end

  kbps_run_ctl #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_ctl (
    .clk       (clk),
    .rst       (rst),
    .start     (acc && (cmd == CMD_RUN)),
    .hold      (pend_valid),
    .mode      (mode),
    .spacing   (spacing),
    .pair_count(pair_count),
    .ctl       (ctl),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .key_addr  (key_addr)
  );

  assign pend_move = pend_valid && (!out_valid || !out_stall);
  assign in_stall  = ctl.busy || (pend_valid && out_valid && out_stall);
  assign acc       = in_valid && !in_stall;

  assign blk_idx_ok = (32'(index) < BLOCK_BYTES);

  always_comb begin
    blk_wr      = ctl.wa || ctl.wb || (acc && (cmd == CMD_WR_BLOCK) && blk_idx_ok);
    blk_wr_addr = AW'(index);
    blk_wr_data = value[7:0];
    if (ctl.wa) begin
      blk_wr_addr = addr_a;
      blk_wr_data = (mode == MODE_BYTE) ? byte_q : pair_q[15:8];
    end else if (ctl.wb) begin
      blk_wr_addr = addr_b;
      blk_wr_data = pair_q[7:0];
    end
    blk_rd      = ctl.rd || (acc && (cmd == CMD_RD_BLOCK) && blk_idx_ok);
    blk_rd_addr = ctl.rd ? addr_a : AW'(index);
  end

  always_ff @(posedge clk) begin
    if (blk_wr) block_mem[blk_wr_addr] <= blk_wr_data;
    if (blk_rd) blk_a_q <= block_mem[blk_rd_addr];
    if (ctl.rd) blk_b_q <= block_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (acc && (cmd == CMD_WR_KEY) && (32'(index) < HALF)) key_mem[KAW'(index)] <= table_sel;
    if (ctl.rd) key_q <= key_mem[key_addr];
  end

  always_comb begin
    if (NUM_TABLES == 1) begin
      key_m = '0;
    end else if (32'(key_q) >= NUM_TABLES) begin
      key_m = key_q - 2'(NUM_TABLES);
    end else begin
      key_m = key_q;
    end
    tbl = (mode == MODE_KEYED) ? TW'(key_m) : '0;
  end

  always_ff @(posedge clk) begin
    if (acc && (cmd == CMD_WR_PAIR) && (32'(table_sel) < NUM_TABLES)) begin
      pair_mem[PAW'({TW'(table_sel), index})] <= value;
    end
    if (ctl.lk) pair_q <= pair_mem[PAW'({tbl, blk_a_q, blk_b_q})];
  end

  always_ff @(posedge clk) begin
    if (acc && (cmd == CMD_WR_BYTE) && (index < 16'd256)) byte_mem[index[7:0]] <= value[7:0];
    if (ctl.lk) byte_q <= byte_mem[blk_a_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if ((acc && (cmd != CMD_RUN)) || ctl.fin) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      pend_rd   <= 1'b0;
      pend_done <= 1'b1;
    end else if (acc) begin
      pend_rd   <= (cmd == CMD_RD_BLOCK) && blk_idx_ok;
      pend_done <= 1'b0;
    end
    if (pend_move) begin
      read_data <= pend_rd ? blk_a_q : 8'd0;
      run_done  <= pend_done;
    end
  end

endmodule

// ===== rtl/kbps_port_check.sv =====
// ----------------------------------------------------------------------------
// Port checker for the keyed byte-pair substitution unit
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module kbps_port_check import kbps_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] cmd,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic       run_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result beat was dropped.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(read_data) && $stable(run_done))
    else $error("Stalled result beat changed.");

  a_done_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_done |-> read_data == 8'd0)
    else $error("Run result carries read data.");

  a_run_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (cmd == CMD_RUN) |=> in_stall)
    else $error("Input not stalled after a run beat.");

endmodule

bind keyed_byte_pair_substitution_unit kbps_port_check u_port_check (.*);
